### hdl/sc1a_pkg.sv
// Shared types, scan code constants and ASCII tables for the set-1 decoder.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package sc1a_pkg;

  localparam int ByteW    = 8;
  localparam int TableLen = 58;
  localparam int IdxW     = $clog2(TableLen);

  typedef logic [ByteW-1:0] byte_t;
  typedef logic [IdxW-1:0]  idx_t;

  // Scan codes
  localparam byte_t SC_PREFIX     = 8'hE0;
  localparam byte_t SC_UP         = 8'h48;
  localparam byte_t SC_LEFT       = 8'h4B;
  localparam byte_t SC_DOWN       = 8'h50;
  localparam byte_t SC_RIGHT      = 8'h4D;
  localparam byte_t SC_PGUP       = 8'h49;
  localparam byte_t SC_PGDN       = 8'h51;
  localparam byte_t SC_CAPS       = 8'h3A;
  localparam byte_t SC_RSHIFT     = 8'h36;
  localparam byte_t SC_LSHIFT     = 8'h2A;
  localparam byte_t SC_RSHIFT_BRK = 8'hB6;
  localparam byte_t SC_LSHIFT_BRK = 8'hAA;
  localparam byte_t SC_CTRL       = 8'h1D;
  localparam byte_t SC_CTRL_BRK   = 8'h9D;

  // Special key numbers
  localparam byte_t SK_UP    = 8'd0;
  localparam byte_t SK_LEFT  = 8'd1;
  localparam byte_t SK_DOWN  = 8'd2;
  localparam byte_t SK_RIGHT = 8'd3;
  localparam byte_t SK_PGUP  = 8'd4;
  localparam byte_t SK_PGDN  = 8'd5;

  localparam byte_t CASE_BIT = 8'h20;

  typedef struct packed {
    logic prefix;
    logic shift;
    logic ctrl;
    logic caps;
  } mod_state_t;

  typedef struct packed {
    logic  emit;
    logic  is_special;
    byte_t code;
    logic  ctrl_held;
  } result_t;

  localparam byte_t TAB_PLAIN [TableLen] = '{
    8'h00, 8'h1B, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36,
    8'h37, 8'h38, 8'h39, 8'h30, 8'h2D, 8'h3D, 8'h08, 8'h09,
    8'h71, 8'h77, 8'h65, 8'h72, 8'h74, 8'h79, 8'h75, 8'h69,
    8'h6F, 8'h70, 8'h5B, 8'h5D, 8'h0A, 8'h00, 8'h61, 8'h73,
    8'h64, 8'h66, 8'h67, 8'h68, 8'h6A, 8'h6B, 8'h6C, 8'h3B,
    8'h27, 8'h60, 8'h00, 8'h5C, 8'h7A, 8'h78, 8'h63, 8'h76,
    8'h62, 8'h6E, 8'h6D, 8'h2C, 8'h2E, 8'h2F, 8'h00, 8'h00,
    8'h00, 8'h20
  };

  localparam byte_t TAB_SHIFT [TableLen] = '{
    8'h00, 8'h1B, 8'h21, 8'h40, 8'h23, 8'h24, 8'h25, 8'h5E,
    8'h26, 8'h2A, 8'h28, 8'h29, 8'h5F, 8'h2B, 8'h08, 8'h09,
    8'h51, 8'h57, 8'h45, 8'h52, 8'h54, 8'h59, 8'h55, 8'h49,
    8'h4F, 8'h50, 8'h7B, 8'h7D, 8'h0A, 8'h00, 8'h41, 8'h53,
    8'h44, 8'h46, 8'h47, 8'h48, 8'h4A, 8'h4B, 8'h4C, 8'h3A,
    8'h22, 8'h7E, 8'h00, 8'h7C, 8'h5A, 8'h58, 8'h43, 8'h56,
    8'h42, 8'h4E, 8'h4D, 8'h3C, 8'h3E, 8'h3F, 8'h00, 8'h00,
    8'h00, 8'h20
  };

  // Letter rows of the keyboard: caps lock flips case only on these.
  function automatic logic is_letter(input idx_t idx);
    return (idx >= 6'h10 && idx <= 6'h19) ||
           (idx >= 6'h1E && idx <= 6'h26) ||
           (idx >= 6'h2C && idx <= 6'h32);
  endfunction

  // idx must be below TableLen
  function automatic byte_t ascii_lookup(input idx_t idx, input logic shift,
                                         input logic caps);
    byte_t base;
    base = shift ? TAB_SHIFT[idx] : TAB_PLAIN[idx];
    return (caps && is_letter(idx)) ? (base ^ CASE_BIT) : base;
  endfunction

endpackage

### hdl/scancode_set1_to_ascii.sv
// Set-1 scan code to ASCII decoder, stream in and stream out.
// Path: an accepted input beat goes to the input register, through the decode
// logic and into the result register, which drives out_tvalid. Throughput: one
// byte per cycle while the output is not stalled; the input register frees in
// the same cycle the result register drains.
// Reset (rst_n low, synchronous) clears the prefix, shift, ctrl and caps state
// and empties both registers. Depends on sc1a_pkg, sc1a_decode, sc1a_mods.
`timescale 1ns / 1ps

module scancode_set1_to_ascii (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] scan_byte
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [7:0] code, [8] ctrl_held, [15:9] zero
  output logic [0:0]  out_tuser   // [0] is_special
);
  import sc1a_pkg::*;

  logic       in_valid_r;
  byte_t      in_byte_r;
  logic       out_valid_r;
  result_t    out_res_r;
  logic       advance;
  mod_state_t cur_st;
  mod_state_t nxt_st;
  result_t    res;

  sc1a_decode u_decode (
    .scan_byte (in_byte_r),
    .cur       (cur_st),
    .nxt       (nxt_st),
    .res       (res)
  );

  sc1a_mods u_mods (
    .clk     (clk),
    .rst_n   (rst_n),
    .advance (advance),
    .nxt     (nxt_st),
    .cur     (cur_st)
  );

  // A beat without a result passes even while the output is stalled.
  assign advance   = in_valid_r && (!res.emit || !out_valid_r || out_tready);
  assign in_tready = !in_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      in_byte_r <= in_tdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance && res.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && res.emit) begin
      out_res_r <= res;
    end
  end

  assign out_tvalid   = out_valid_r;
  assign out_tdata    = {7'b0, out_res_r.ctrl_held, out_res_r.code};
  assign out_tuser[0] = out_res_r.is_special;

  a_prefix_arms: assert property (@(posedge clk) disable iff (!rst_n)
    advance && in_byte_r == SC_PREFIX |=> cur_st.prefix)
    else $error("prefix byte did not arm the prefix flag");

  a_prefix_clears: assert property (@(posedge clk) disable iff (!rst_n)
    advance && cur_st.prefix && in_byte_r != SC_PREFIX |=> !cur_st.prefix)
    else $error("prefixed byte left the prefix flag armed");

  a_caps_toggle: assert property (@(posedge clk) disable iff (!rst_n)
    advance && !cur_st.prefix && in_byte_r == SC_CAPS |=>
      cur_st.caps != $past(cur_st.caps))
    else $error("caps lock byte did not toggle caps state");

  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid_r && !advance |=> in_valid_r && $stable(in_byte_r) && $stable(cur_st))
    else $error("stalled input beat lost or state moved");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_tready |=> out_valid_r && $stable(out_res_r))
    else $error("pending result overwritten");

endmodule

### hdl/sc1a_decode.sv
// Per-byte decode: next modifier state and the optional result for one beat.
// Depends on sc1a_pkg for codes, tables and structs.
`timescale 1ns / 1ps

module sc1a_decode (
  input  sc1a_pkg::byte_t      scan_byte,
  input  sc1a_pkg::mod_state_t cur,
  output sc1a_pkg::mod_state_t nxt,
  output sc1a_pkg::result_t    res
);
  import sc1a_pkg::*;

  always_comb begin
    nxt            = cur;
    res.emit       = 1'b0;
    res.is_special = 1'b0;
    res.code       = '0;
    res.ctrl_held  = cur.ctrl;

    if (scan_byte == SC_PREFIX) begin
      nxt.prefix = 1'b1;
    end else if (cur.prefix) begin
      nxt.prefix = 1'b0;
      res.is_special = 1'b1;
      unique case (scan_byte)
        SC_UP: begin
          res.emit = 1'b1;
          res.code = SK_UP;
        end
        SC_LEFT: begin
          res.emit = 1'b1;
          res.code = SK_LEFT;
        end
        SC_DOWN: begin
          res.emit = 1'b1;
          res.code = SK_DOWN;
        end
        SC_RIGHT: begin
          res.emit = 1'b1;
          res.code = SK_RIGHT;
        end
        SC_PGUP: begin
          res.emit = 1'b1;
          res.code = SK_PGUP;
        end
        SC_PGDN: begin
          res.emit = 1'b1;
          res.code = SK_PGDN;
        end
        SC_CTRL:     nxt.ctrl = 1'b1;
        SC_CTRL_BRK: nxt.ctrl = 1'b0;
        default: ;
      endcase
    end else begin
      unique case (scan_byte) inside
        SC_LSHIFT, SC_RSHIFT:         nxt.shift = 1'b1;
        SC_LSHIFT_BRK, SC_RSHIFT_BRK: nxt.shift = 1'b0;
        SC_CTRL:                      nxt.ctrl  = 1'b1;
        SC_CTRL_BRK:                  nxt.ctrl  = 1'b0;
        SC_CAPS:                      nxt.caps  = ~cur.caps;
        default: begin
          // break codes and keys past the tables drop silently
          if (scan_byte < byte_t'(TableLen)) begin
            res.emit = 1'b1;
            res.code = ascii_lookup(scan_byte[IdxW-1:0], cur.shift, cur.caps);
          end
        end
      endcase
    end
  end

endmodule

### hdl/sc1a_mods.sv
// Modifier and prefix state registers, updated once per decoded beat.
// Depends on sc1a_pkg for mod_state_t.
`timescale 1ns / 1ps

module sc1a_mods (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 advance,
  input  sc1a_pkg::mod_state_t nxt,
  output sc1a_pkg::mod_state_t cur
);
  import sc1a_pkg::*;

  mod_state_t state_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= '0;
    end else if (advance) begin
      state_r <= nxt;
    end
  end

  assign cur = state_r;

endmodule

### verif/scancode_set1_to_ascii_test.sv
// Self-checking bench for scancode_set1_to_ascii: drives set-1 bytes over the
// input stream and compares each decoded key beat with an in-bench key decoder.
// Depends on sc1a_pkg (scan code and special key constants) and the block RTL.
`timescale 1ns / 1ps

module scancode_set1_to_ascii_test;
  import sc1a_pkg::*;

  localparam int KeyRows     = 58;
  localparam int IdlePct     = 8;
  localparam int ByteTarget  = 1350;
  localparam int QuietLimit  = 1000;
  localparam int DrainCycles = 8;
  localparam int SteadyFrom  = 400;
  localparam int SteadyTo    = 700;

  localparam logic [7:0] KEYS_PLAIN [KeyRows] = '{
    8'h00, 8'h1B, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36,
    8'h37, 8'h38, 8'h39, 8'h30, 8'h2D, 8'h3D, 8'h08, 8'h09,
    8'h71, 8'h77, 8'h65, 8'h72, 8'h74, 8'h79, 8'h75, 8'h69,
    8'h6F, 8'h70, 8'h5B, 8'h5D, 8'h0A, 8'h00, 8'h61, 8'h73,
    8'h64, 8'h66, 8'h67, 8'h68, 8'h6A, 8'h6B, 8'h6C, 8'h3B,
    8'h27, 8'h60, 8'h00, 8'h5C, 8'h7A, 8'h78, 8'h63, 8'h76,
    8'h62, 8'h6E, 8'h6D, 8'h2C, 8'h2E, 8'h2F, 8'h00, 8'h00,
    8'h00, 8'h20
  };

  localparam logic [7:0] KEYS_SHIFT [KeyRows] = '{
    8'h00, 8'h1B, 8'h21, 8'h40, 8'h23, 8'h24, 8'h25, 8'h5E,
    8'h26, 8'h2A, 8'h28, 8'h29, 8'h5F, 8'h2B, 8'h08, 8'h09,
    8'h51, 8'h57, 8'h45, 8'h52, 8'h54, 8'h59, 8'h55, 8'h49,
    8'h4F, 8'h50, 8'h7B, 8'h7D, 8'h0A, 8'h00, 8'h41, 8'h53,
    8'h44, 8'h46, 8'h47, 8'h48, 8'h4A, 8'h4B, 8'h4C, 8'h3A,
    8'h22, 8'h7E, 8'h00, 8'h7C, 8'h5A, 8'h58, 8'h43, 8'h56,
    8'h42, 8'h4E, 8'h4D, 8'h3C, 8'h3E, 8'h3F, 8'h00, 8'h00,
    8'h00, 8'h20
  };

  // Directed opening: table extremes, bytes past the table, shift and caps
  // combinations, ctrl both ways, every special key but page down and a repeated prefix.
  localparam logic [7:0] OPENING [26] = '{
    8'h00, 8'hFF, 8'h39, 8'h3B,
    SC_LSHIFT, 8'h1E, SC_CAPS, 8'h1E, SC_LSHIFT_BRK, 8'h1E, SC_CAPS,
    SC_PREFIX, SC_CTRL, 8'h10, SC_CTRL_BRK,
    SC_PREFIX, SC_UP, SC_PREFIX, SC_PREFIX, SC_LEFT, SC_PREFIX, SC_DOWN,
    SC_PREFIX, SC_RIGHT, SC_PREFIX, SC_PGUP
  };

  localparam logic [7:0] PREFIXED [8] = '{
    SC_UP, SC_LEFT, SC_DOWN, SC_RIGHT, SC_PGUP, SC_PGDN, SC_CTRL, SC_CTRL_BRK
  };

  localparam logic [7:0] SHIFTS [4] = '{
    SC_LSHIFT, SC_RSHIFT, SC_LSHIFT_BRK, SC_RSHIFT_BRK
  };

  typedef struct {
    logic       is_special;
    logic [7:0] code;
    logic       ctrl;
  } key_result_t;

  class key_decode_sb;
    bit          prefix_seen;
    bit          shift_held;
    bit          ctrl_held;
    bit          caps_locked;
    key_result_t pending_keys[$];
    int          n_errors;
    int          n_checked;
    int          n_special;

    // Caps lock flips the case of letters only, in either table.
    function logic [7:0] ascii_of(logic [7:0] scan);
      logic [7:0] ch;
      ch = shift_held ? KEYS_SHIFT[scan[5:0]] : KEYS_PLAIN[scan[5:0]];
      if (caps_locked && ((ch >= 8'h41 && ch <= 8'h5A) || (ch >= 8'h61 && ch <= 8'h7A)))
        ch = ch ^ 8'h20;
      return ch;
    endfunction

    function void note_scan(logic [7:0] scan);
      key_result_t k;
      bit          hit;
      hit          = 1'b0;
      k.is_special = 1'b1;
      k.code       = 8'h00;
      if (scan == SC_PREFIX) begin
        prefix_seen = 1'b1;
        return;
      end
      if (prefix_seen) begin
        prefix_seen = 1'b0;
        hit = 1'b1;
        case (scan)
          SC_UP:       k.code = SK_UP;
          SC_LEFT:     k.code = SK_LEFT;
          SC_DOWN:     k.code = SK_DOWN;
          SC_RIGHT:    k.code = SK_RIGHT;
          SC_PGUP:     k.code = SK_PGUP;
          SC_PGDN:     k.code = SK_PGDN;
          SC_CTRL:     begin ctrl_held = 1'b1; hit = 1'b0; end
          SC_CTRL_BRK: begin ctrl_held = 1'b0; hit = 1'b0; end
          default:     hit = 1'b0;
        endcase
      end else begin
        case (scan)
          SC_LSHIFT, SC_RSHIFT:         shift_held = 1'b1;
          SC_LSHIFT_BRK, SC_RSHIFT_BRK: shift_held = 1'b0;
          SC_CTRL:                      ctrl_held = 1'b1;
          SC_CTRL_BRK:                  ctrl_held = 1'b0;
          SC_CAPS:                      caps_locked = !caps_locked;
          default: begin
            if (scan < KeyRows) begin
              hit = 1'b1;
              k.is_special = 1'b0;
              k.code = ascii_of(scan);
            end
          end
        endcase
      end
      if (hit) begin
        k.ctrl = ctrl_held;
        pending_keys.push_back(k);
      end
    endfunction

    function void check_key(logic is_special, logic [7:0] code, logic ctrl);
      key_result_t k;
      if (pending_keys.size() == 0) begin
        $error("unexpected key beat: is_special %0d code 0x%02h ctrl_held %0d",
               is_special, code, ctrl);
        n_errors++;
        return;
      end
      k = pending_keys.pop_front();
      n_checked++;
      if (k.is_special) n_special++;
      if (is_special !== k.is_special) begin
        $error("is_special: expected %0d, got %0d", k.is_special, is_special);
        n_errors++;
      end
      if (code !== k.code) begin
        $error("code: expected 0x%02h, got 0x%02h", k.code, code);
        n_errors++;
      end
      if (ctrl !== k.ctrl) begin
        $error("ctrl_held: expected %0d, got %0d", k.ctrl, ctrl);
        n_errors++;
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [7:0]  in_tdata;   // [7:0] scan_byte
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [15:0] out_tdata;  // [7:0] code, [8] ctrl_held, [15:9] zero
  logic [0:0]  out_tuser;  // [0] is_special

  key_decode_sb sb = new();
  bit           steady = 1'b0;
  int           n_sent = 0;
  int           quiet_cycles = 0;

  always #10 clk = ~clk;

  scancode_set1_to_ascii u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always @(posedge clk) begin
    out_tready <= steady || ($urandom_range(99) >= IdlePct);
  end

  // Sample both channels on pre-edge values; bail out if traffic stops.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) sb.note_scan(in_tdata);
      if (out_tvalid && out_tready) sb.check_key(out_tuser[0], out_tdata[7:0], out_tdata[8]);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= QuietLimit) begin
        $error("no beat accepted for %0d cycles", QuietLimit);
        $display("status: fail");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // Call at a rising edge; returns at the edge where the beat is taken.
  task automatic send_scan(input logic [7:0] scan);
    if (!steady) begin
      while ($urandom_range(99) < IdlePct) begin
        in_tvalid <= 1'b0;
        in_tdata  <= 8'($urandom);
        @(posedge clk);
      end
    end
    in_tvalid <= 1'b1;
    in_tdata  <= scan;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    n_sent++;
  endtask

  // One keyboard event: mostly well-formed make, break and prefixed
  // sequences, with some raw noise mixed in.
  task automatic send_keystroke();
    int pick;
    pick = $urandom_range(99);
    if (pick < 45) begin
      send_scan(8'($urandom_range(KeyRows - 1)));
    end else if (pick < 55) begin
      send_scan(8'h80 | 8'($urandom_range(127)));
    end else if (pick < 65) begin
      send_scan(SHIFTS[$urandom_range(3)]);
    end else if (pick < 70) begin
      send_scan(SC_CAPS);
    end else if (pick < 75) begin
      send_scan($urandom_range(1) ? SC_CTRL : SC_CTRL_BRK);
    end else if (pick < 88) begin
      send_scan(SC_PREFIX);
      pick = $urandom_range(11);
      if (pick < 8) send_scan(PREFIXED[pick]);
      else if (pick < 10) send_scan(8'h80 | PREFIXED[$urandom_range(5)]);
      else if (pick == 10) send_scan(SC_PREFIX);
      else send_scan(8'($urandom));
    end else begin
      send_scan(8'($urandom));
    end
  endtask

  initial begin
    int n_keys;
    rst_n      = 1'b0;
    in_tvalid  = 1'b0;
    in_tdata   = 8'h00;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    foreach (OPENING[i]) send_scan(OPENING[i]);

    n_keys = 0;
    while (n_sent < ByteTarget) begin
      steady = (n_keys >= SteadyFrom) && (n_keys < SteadyTo);
      send_keystroke();
      n_keys++;
    end
    steady = 1'b0;
    in_tvalid <= 1'b0;
    @(posedge clk);

    while (sb.pending_keys.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);

    $display("Sent %0d scan bytes; checked %0d key beats, %0d of them special keys.",
             n_sent, sb.n_checked, sb.n_special);
    if (sb.n_errors == 0) begin
      $display("status: pass");
    end else begin
      $display("%0d mismatches found.", sb.n_errors);
      $display("status: fail");
    end
    $finish;
  end

endmodule

### sim.f
hdl/sc1a_pkg.sv
hdl/sc1a_decode.sv
hdl/sc1a_mods.sv
hdl/scancode_set1_to_ascii.sv
verif/scancode_set1_to_ascii_test.sv
